// ----- src/cvfm_pkg.sv -----
// Shared types, codes and constants for the cell voltage fault monitor.
// No dependencies; imported by every other file of the block.
`default_nettype none

package cvfm_pkg;

    localparam int CellIdxW = 7;
    localparam int NumCells = 1 << CellIdxW;
    localparam int CountW   = 8;
    localparam int ThrW     = 15;
    localparam int LimitW   = 8;
    localparam int MvW      = 16;
    localparam int SumW     = 23;
    localparam int CfgIdxW  = 2;
    localparam int CfgDataW = 15;

    localparam logic [CountW-1:0] COUNT_MAX = {CountW{1'b1}};

    localparam logic [ThrW-1:0]   UV_THR_RST    = 15'd3000;
    localparam logic [ThrW-1:0]   OV_THR_RST    = 15'd4200;
    localparam logic [LimitW-1:0] LIMIT_RST     = 8'd3;
    localparam logic [ThrW-1:0]   TOLERANCE_RST = 15'd100;

    localparam logic signed [MvW-1:0]  MV_MOST_POS = 16'sh7FFF;
    localparam logic signed [MvW-1:0]  MV_MOST_NEG = 16'sh8000;
    localparam logic signed [SumW-1:0] SUM_MAX     = 23'sh3F_FFFF;
    localparam logic signed [SumW-1:0] SUM_MIN     = 23'sh40_0000;

    typedef enum logic [1:0] {
        KIND_CELL = 2'd0,
        KIND_BANK = 2'd1,
        KIND_PACK = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ERR_NONE = 2'd0,
        ERR_UV   = 2'd1,
        ERR_OV   = 2'd2
    } t_err;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_UV_THR       = 2'd0,
        CFG_OV_THR       = 2'd1,
        CFG_FAULT_LIMIT  = 2'd2,
        CFG_MISMATCH_TOL = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [ThrW-1:0]   uv_thr;
        logic [ThrW-1:0]   ov_thr;
        logic [LimitW-1:0] limit;
        logic [ThrW-1:0]   tol;
    } t_cfg;

    typedef struct packed {
        logic [CellIdxW-1:0]   cell_index;
        logic signed [MvW-1:0] primary_mv;
        logic signed [MvW-1:0] redundant_mv;
        logic                  bank_last;
        logic                  frame_last;
    } t_item;

    typedef struct packed {
        logic [CountW-1:0] uc;
        logic [CountW-1:0] oc;
    } t_counts;

    typedef struct packed {
        logic uv_fault;
        logic ov_fault;
        logic mismatch;
    } t_cell_flags;

    typedef struct packed {
        logic signed [SumW-1:0] total;
        logic signed [MvW-1:0]  low;
        logic signed [MvW-1:0]  high;
    } t_stats;

    typedef struct packed {
        t_err                code;
        logic [CellIdxW-1:0] cell_idx;
    } t_err_info;

    localparam t_stats STATS_RST = '{total: '0, low: MV_MOST_POS, high: MV_MOST_NEG};

    function automatic logic signed [SumW-1:0] sat_add(
        input logic signed [SumW-1:0] a,
        input logic signed [MvW-1:0]  b
    );
        logic signed [SumW:0] s;
        s = {a[SumW-1], a} + {{(SumW+1-MvW){b[MvW-1]}}, b};
        if (s[SumW:SumW-1] == 2'b01) begin
            return SUM_MAX;
        end else if (s[SumW:SumW-1] == 2'b10) begin
            return SUM_MIN;
        end
        return s[SumW-1:0];
    endfunction

    function automatic t_stats stats_add(input t_stats st, input logic signed [MvW-1:0] p);
        t_stats n;
        n.total = sat_add(st.total, p);
        n.low   = (p < st.low)  ? p : st.low;
        n.high  = (p > st.high) ? p : st.high;
        return n;
    endfunction

endpackage

`default_nettype wire

// ----- src/cell_voltage_fault_monitor.sv -----
// Top level of the cell voltage fault monitor: input register, count memory,
// evaluation and result register. Depends on cvfm_pkg and all cvfm_* modules.
//
//   channel   direction  handshake                 payload
//   sample    in         i_valid / o_stall         cell index, primary, redundant, bank/frame end
//   result    out        o_valid / i_stall         kind, flags, totals, min/max, error, last
//   config    in         i_cfg_valid / o_cfg_ready register index, data
//
// One sample per cycle while o_stall is low; its first result is presented once the sample has passed
// stage 1 into the result register. A sample with a bank or frame end gives two or three results,
// one per cycle while i_stall is low, and holds the input until the single result register hands out its last.
// Synchronous active-low reset clears counts (valid bits), accumulators, latch, stage 1 valid and pending results.
// Stalls: o_stall rises only while stage 1 holds an item the result register
// cannot take.
`default_nettype none

module cell_voltage_fault_monitor (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_valid,
    output logic                             o_stall,
    input  wire  [cvfm_pkg::CellIdxW-1:0]    i_cell_index,
    input  wire  signed [cvfm_pkg::MvW-1:0]  i_primary_mv,
    input  wire  signed [cvfm_pkg::MvW-1:0]  i_redundant_mv,
    input  wire                              i_bank_last,
    input  wire                              i_frame_last,
    output logic                             o_valid,
    input  wire                              i_stall,
    output logic [1:0]                       o_kind,
    output logic                             o_uv_fault,
    output logic                             o_ov_fault,
    output logic                             o_mismatch,
    output logic signed [cvfm_pkg::SumW-1:0] o_total_mv,
    output logic signed [cvfm_pkg::MvW-1:0]  o_min_mv,
    output logic signed [cvfm_pkg::MvW-1:0]  o_max_mv,
    output logic [1:0]                       o_error_code,
    output logic [cvfm_pkg::CellIdxW-1:0]    o_fault_cell,
    output logic                             o_last_result,
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire  [cvfm_pkg::CfgIdxW-1:0]     i_cfg_index,
    input  wire  [cvfm_pkg::CfgDataW-1:0]    i_cfg_data
);
    import cvfm_pkg::*;

    t_cfg        cfg;
    logic        r_s1_vld;
    t_item       r_s1_item;
    logic        in_xfer;
    logic        s1_fire;
    logic        buf_ready;
    t_counts     rd_counts;
    t_counts     new_counts;
    t_cell_flags flags;
    t_stats      bank_snap;
    t_stats      pack_snap;
    t_err_info   err_snap;

    assign s1_fire = r_s1_vld && buf_ready;
    assign o_stall = r_s1_vld && !buf_ready;
    assign in_xfer = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (!o_stall) begin
            r_s1_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_item <= '{cell_index:   i_cell_index,
                           primary_mv:   i_primary_mv,
                           redundant_mv: i_redundant_mv,
                           bank_last:    i_bank_last,
                           frame_last:   i_frame_last};
        end
    end

    cvfm_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (cfg)
    );

    cvfm_count_mem u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_xfer),
        .i_rd_addr (i_cell_index),
        .i_wr_en   (s1_fire),
        .i_wr_addr (r_s1_item.cell_index),
        .i_wr_data (new_counts),
        .o_rd_data (rd_counts)
    );

    cvfm_eval u_eval (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (s1_fire),
        .i_item   (r_s1_item),
        .i_cfg    (cfg),
        .i_counts (rd_counts),
        .o_counts (new_counts),
        .o_flags  (flags),
        .o_bank   (bank_snap),
        .o_pack   (pack_snap),
        .o_err    (err_snap)
    );

    cvfm_out_buf u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (s1_fire),
        .i_bank_last   (r_s1_item.bank_last),
        .i_frame_last  (r_s1_item.frame_last),
        .i_flags       (flags),
        .i_bank        (bank_snap),
        .i_pack        (pack_snap),
        .i_err         (err_snap),
        .i_stall       (i_stall),
        .o_ready       (buf_ready),
        .o_valid       (o_valid),
        .o_kind        (o_kind),
        .o_uv_fault    (o_uv_fault),
        .o_ov_fault    (o_ov_fault),
        .o_mismatch    (o_mismatch),
        .o_total_mv    (o_total_mv),
        .o_min_mv      (o_min_mv),
        .o_max_mv      (o_max_mv),
        .o_error_code  (o_error_code),
        .o_fault_cell  (o_fault_cell),
        .o_last_result (o_last_result)
    );

    a_xfer_fills_s1 : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> r_s1_vld)
        else $error("sample transfer did not reach stage 1");

    a_results_continue : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !o_last_result) |=> o_valid)
        else $error("result sequence broken before its last result");

    a_pack_is_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_kind == KIND_PACK)) |-> o_last_result)
        else $error("pack summary not flagged as last result");

    a_fire_loads_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_fire |=> (o_valid && (o_kind == KIND_CELL)))
        else $error("stage 1 hand-over did not present a cell result");

endmodule

`default_nettype wire

// ----- src/cvfm_cfg_regs.sv -----
// Configuration registers: thresholds, fault count limit and mismatch tolerance.
// Depends on cvfm_pkg.
`default_nettype none

module cvfm_cfg_regs (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_cfg_valid,
    input  wire  [cvfm_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  wire  [cvfm_pkg::CfgDataW-1:0] i_cfg_data,
    output logic                          o_cfg_ready,
    output cvfm_pkg::t_cfg                o_cfg
);
    import cvfm_pkg::*;

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.uv_thr <= UV_THR_RST;
            r_cfg.ov_thr <= OV_THR_RST;
            r_cfg.limit  <= LIMIT_RST;
            r_cfg.tol    <= TOLERANCE_RST;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_UV_THR:       r_cfg.uv_thr <= i_cfg_data[ThrW-1:0];
                CFG_OV_THR:       r_cfg.ov_thr <= i_cfg_data[ThrW-1:0];
                CFG_FAULT_LIMIT:  r_cfg.limit  <= i_cfg_data[LimitW-1:0];
                CFG_MISMATCH_TOL: r_cfg.tol    <= i_cfg_data[ThrW-1:0];
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- src/cvfm_count_mem.sv -----
// Per-cell under/over-voltage count memory with valid bits and write bypass.
// Depends on cvfm_pkg.
`default_nettype none

module cvfm_count_mem (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_rd_en,
    input  wire  [cvfm_pkg::CellIdxW-1:0] i_rd_addr,
    input  wire                           i_wr_en,
    input  wire  [cvfm_pkg::CellIdxW-1:0] i_wr_addr,
    input  cvfm_pkg::t_counts             i_wr_data,
    output cvfm_pkg::t_counts             o_rd_data
);
    import cvfm_pkg::*;

    t_counts             r_mem [NumCells];
    logic [NumCells-1:0] r_vld;
    t_counts             r_rd;

    assign o_rd_data = r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr_en) begin
            r_vld[i_wr_addr] <= 1'b1;
        end
    end

    // bypass the write of the item leaving stage 1 to the item entering
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
                r_rd <= i_wr_data;
            end else if (!r_vld[i_rd_addr]) begin
                r_rd <= '0;
            end else begin
                r_rd <= r_mem[i_rd_addr];
            end
        end
    end

endmodule

`default_nettype wire

// ----- src/cvfm_eval.sv -----
// Per-sample evaluation: count update, fault and mismatch flags, bank and pack
// accumulators and the error latch. Depends on cvfm_pkg.
`default_nettype none

module cvfm_eval (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_fire,
    input  cvfm_pkg::t_item     i_item,
    input  cvfm_pkg::t_cfg      i_cfg,
    input  cvfm_pkg::t_counts   i_counts,
    output cvfm_pkg::t_counts   o_counts,
    output cvfm_pkg::t_cell_flags o_flags,
    output cvfm_pkg::t_stats    o_bank,
    output cvfm_pkg::t_stats    o_pack,
    output cvfm_pkg::t_err_info o_err
);
    import cvfm_pkg::*;

    t_stats    r_bank;
    t_stats    r_pack;
    t_err_info r_err;

    logic signed [MvW:0] p_x;
    logic signed [MvW:0] r_x;
    logic signed [MvW:0] diff;
    logic        [MvW:0] abs_diff;
    logic                uv_hit;
    logic                ov_hit;
    logic [CountW-1:0]   uc_inc;
    logic [CountW-1:0]   oc_inc;
    t_stats              bank_next;
    t_stats              pack_next;
    t_err_info           err_next;

    always_comb begin
        p_x      = {i_item.primary_mv[MvW-1], i_item.primary_mv};
        r_x      = {i_item.redundant_mv[MvW-1], i_item.redundant_mv};
        diff     = p_x - r_x;
        abs_diff = diff[MvW] ? unsigned'(-diff) : unsigned'(diff);
        o_flags.mismatch = abs_diff > {2'b00, i_cfg.tol};

        uv_hit = p_x < $signed({2'b00, i_cfg.uv_thr});
        ov_hit = p_x > $signed({2'b00, i_cfg.ov_thr});
        uc_inc = (i_counts.uc == COUNT_MAX) ? i_counts.uc : i_counts.uc + 1'b1;
        oc_inc = (i_counts.oc == COUNT_MAX) ? i_counts.oc : i_counts.oc + 1'b1;

        o_counts.uc      = uv_hit ? uc_inc : '0;
        o_counts.oc      = ov_hit ? oc_inc : '0;
        o_flags.uv_fault = uv_hit && (uc_inc >= i_cfg.limit);
        o_flags.ov_fault = ov_hit && (oc_inc >= i_cfg.limit);

        // over-voltage wins when both are raised
        err_next = r_err;
        if (o_flags.ov_fault) begin
            err_next = '{code: ERR_OV, cell_idx: i_item.cell_index};
        end else if (o_flags.uv_fault) begin
            err_next = '{code: ERR_UV, cell_idx: i_item.cell_index};
        end

        bank_next = stats_add(r_bank, i_item.primary_mv);
        pack_next = stats_add(r_pack, i_item.primary_mv);
    end

    assign o_bank = bank_next;
    assign o_pack = pack_next;
    assign o_err  = err_next;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank <= STATS_RST;
            r_pack <= STATS_RST;
            r_err  <= '{code: ERR_NONE, cell_idx: '0};
        end else if (i_fire) begin
            r_bank <= (i_item.bank_last || i_item.frame_last) ? STATS_RST : bank_next;
            r_pack <= i_item.frame_last ? STATS_RST : pack_next;
            r_err  <= i_item.frame_last ? '{code: ERR_NONE, cell_idx: '0} : err_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/cvfm_out_buf.sv -----
// Result register: holds the cell result and the bank/pack summaries of one
// item and hands them out in order. Depends on cvfm_pkg.
`default_nettype none

module cvfm_out_buf (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_load,
    input  wire                           i_bank_last,
    input  wire                           i_frame_last,
    input  cvfm_pkg::t_cell_flags         i_flags,
    input  cvfm_pkg::t_stats              i_bank,
    input  cvfm_pkg::t_stats              i_pack,
    input  cvfm_pkg::t_err_info           i_err,
    input  wire                           i_stall,
    output logic                          o_ready,
    output logic                          o_valid,
    output logic [1:0]                    o_kind,
    output logic                          o_uv_fault,
    output logic                          o_ov_fault,
    output logic                          o_mismatch,
    output logic signed [cvfm_pkg::SumW-1:0] o_total_mv,
    output logic signed [cvfm_pkg::MvW-1:0]  o_min_mv,
    output logic signed [cvfm_pkg::MvW-1:0]  o_max_mv,
    output logic [1:0]                    o_error_code,
    output logic [cvfm_pkg::CellIdxW-1:0] o_fault_cell,
    output logic                          o_last_result
);
    import cvfm_pkg::*;

    logic        r_pend_cell;
    logic        r_pend_bank;
    logic        r_pend_pack;
    t_cell_flags r_flags;
    t_stats      r_bank;
    t_stats      r_pack;
    t_err_info   r_err;

    logic        one_left;
    logic        out_xfer;

    assign o_valid       = r_pend_cell || r_pend_bank || r_pend_pack;
    assign one_left      = $countones({r_pend_cell, r_pend_bank, r_pend_pack}) == 1;
    assign out_xfer      = o_valid && !i_stall;
    assign o_ready       = !o_valid || (out_xfer && one_left);
    assign o_last_result = one_left;

    always_comb begin
        o_kind       = KIND_CELL;
        o_uv_fault   = 1'b0;
        o_ov_fault   = 1'b0;
        o_mismatch   = 1'b0;
        o_total_mv   = '0;
        o_min_mv     = '0;
        o_max_mv     = '0;
        o_error_code = ERR_NONE;
        o_fault_cell = '0;
        priority if (r_pend_cell) begin
            o_uv_fault = r_flags.uv_fault;
            o_ov_fault = r_flags.ov_fault;
            o_mismatch = r_flags.mismatch;
        end else if (r_pend_bank) begin
            o_kind     = KIND_BANK;
            o_total_mv = r_bank.total;
            o_min_mv   = r_bank.low;
            o_max_mv   = r_bank.high;
        end else begin
            o_kind       = KIND_PACK;
            o_total_mv   = r_pack.total;
            o_min_mv     = r_pack.low;
            o_max_mv     = r_pack.high;
            o_error_code = r_err.code;
            o_fault_cell = r_err.cell_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_cell <= 1'b0;
            r_pend_bank <= 1'b0;
            r_pend_pack <= 1'b0;
        end else if (i_load) begin
            r_pend_cell <= 1'b1;
            r_pend_bank <= i_bank_last;
            r_pend_pack <= i_frame_last;
        end else if (out_xfer) begin
            priority if (r_pend_cell) begin
                r_pend_cell <= 1'b0;
            end else if (r_pend_bank) begin
                r_pend_bank <= 1'b0;
            end else begin
                r_pend_pack <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_flags <= i_flags;
            r_bank  <= i_bank;
            r_pack  <= i_pack;
            r_err   <= i_err;
        end
    end

endmodule

`default_nettype wire
